### sv/ssr_pkg.sv
// shared constants and helpers for the stepper shuttle with ramp unit
package ssr_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_STAGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_TICKS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS       = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    // half-step sequence and timing constants
    localparam int unsigned PHASES  = 8;
    localparam int unsigned PHASE_W = $clog2(PHASES);
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned PERIOD_W = 20;
    localparam logic [3:0] LEVEL_TOP = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // coil pattern for a phase, forward when heading right, reversed otherwise
    function automatic logic [3:0] pattern_of(input logic [PHASE_W-1:0] idx,
                                              input logic dir_right);
        logic [PHASE_W-1:0] pos;
        logic [3:0]         pat;
        pos = dir_right ? idx : (PHASE_W'(PHASES - 1) - idx);
        case (pos)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hA;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'h5;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    // number of levels below the top, zero at or above it
    function automatic logic [3:0] below_top(input logic [4:0] lvl);
        logic [4:0] diff;
        diff = {1'b0, LEVEL_TOP} - lvl;
        return (lvl >= {1'b0, LEVEL_TOP}) ? 4'd0 : diff[3:0];
    endfunction

endpackage

### sv/stepper_shuttle_with_ramp_unit.sv
// stepper shuttle controller with acceleration ramp, half-step coil drive
// a tick beat waits in the input register; its result is registered into the output register
// throughput: one tick beat per cycle while results are taken; input and result registers split the handshakes
// the combinational state update (period multiply, ramp bookkeeping) sets the pace
// reset: async active low; motion stopped, coils off, registers at defaults
module stepper_shuttle_with_ramp_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // start_cmd, abort_cmd, left_limit, right_limit, pad
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // coil_drive[3:0], moving, heading_right, ramping, reversed_now
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [3:0]  speed_level_reg;
    logic [3:0]  accel_level_reg;
    logic [7:0]  cycles_per_stage_reg;
    logic [15:0] base_ticks_reg;
    logic [15:0] unit_ticks_reg;

    // handshake registers
    logic       in_valid_reg;
    logic [3:0] in_data_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       advance;
    logic       fire;

    // motion state
    logic                         running_reg, running_next;
    logic                         direction_reg, direction_next;
    logic [ssr_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [ssr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [4:0]                   ramp_level_reg, ramp_level_next;
    logic [3:0]                   stages_left_reg, stages_left_next;
    logic [7:0]                   cycles_in_stage_reg, cycles_in_stage_next;
    logic                         ramp_active_reg, ramp_active_next;

    // ramp start values
    logic [3:0] ramp_stages;
    logic [4:0] ramp_init_level;
    logic       ramp_init_active;

    // result fields
    logic [3:0] coils;
    logic       rev;
    logic [7:0] result;

    // tick fields
    logic in_start;
    logic in_abort;
    logic in_left;
    logic in_right;

    assign in_start = in_data_reg[0];
    assign in_abort = in_data_reg[1];
    assign in_left  = in_data_reg[2];
    assign in_right = in_data_reg[3];

    // handshake control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // ramp start values from the current settings
    always_comb
    begin
        ramp_stages = (accel_level_reg >= ssr_pkg::LEVEL_TOP) ? 4'd0
                    : (ssr_pkg::LEVEL_TOP - accel_level_reg);
        ramp_init_level = (speed_level_reg >= ramp_stages)
                        ? {1'b0, speed_level_reg - ramp_stages}
                        : {1'b0, ramp_stages - speed_level_reg};
        ramp_init_active = (ramp_stages != 4'd0) && (cycles_per_stage_reg != 8'd0);
    end

    // next state and result for one tick
    always_comb
    begin
        logic                        hit;
        logic [4:0]                  lvl;
        logic [3:0]                  below;
        logic [ssr_pkg::PERIOD_W-1:0] period;
        logic [ssr_pkg::PERIOD_W-1:0] period_m1;

        running_next         = running_reg;
        direction_next       = direction_reg;
        phase_next           = phase_reg;
        count_next           = count_reg;
        ramp_level_next      = ramp_level_reg;
        stages_left_next     = stages_left_reg;
        cycles_in_stage_next = cycles_in_stage_reg;
        ramp_active_next     = ramp_active_reg;
        coils                = 4'd0;
        rev                  = 1'b0;
        hit                  = 1'b0;
        lvl                  = 5'd0;
        below                = 4'd0;
        period               = '0;
        period_m1            = '0;

        if (in_abort)
        begin
            running_next     = 1'b0;
            ramp_active_next = 1'b0;
            count_next       = '0;
            phase_next       = '0;
        end
        else
        begin
            // start from idle heads left with a fresh ramp
            if (!running_reg && in_start)
            begin
                running_next         = 1'b1;
                direction_next       = 1'b0;
                phase_next           = '0;
                count_next           = '0;
                ramp_level_next      = ramp_init_level;
                stages_left_next     = ramp_stages;
                cycles_in_stage_next = 8'd0;
                ramp_active_next     = ramp_init_active;
            end
            if (running_next)
            begin
                if (count_next != '0)
                begin
                    // hold the current half-step
                    count_next = count_next - 1'b1;
                    coils = ssr_pkg::pattern_of(phase_next - 1'b1, direction_next);
                end
                else
                begin
                    hit = direction_next ? in_right : in_left;
                    if (phase_next == '0 && hit)
                    begin
                        // limit at a cycle boundary: coils off, turn round, new ramp
                        direction_next       = !direction_next;
                        rev                  = 1'b1;
                        ramp_level_next      = ramp_init_level;
                        stages_left_next     = ramp_stages;
                        cycles_in_stage_next = 8'd0;
                        ramp_active_next     = ramp_init_active;
                    end
                    else
                    begin
                        coils = ssr_pkg::pattern_of(phase_next, direction_next);
                        // half-step period from the active level
                        lvl = ramp_active_next ? ramp_level_next : {1'b0, speed_level_reg};
                        below = ssr_pkg::below_top(lvl);
                        period = {4'd0, base_ticks_reg}
                               + (ssr_pkg::PERIOD_W'(unit_ticks_reg)
                                  * ssr_pkg::PERIOD_W'(below));
                        period_m1 = (period == '0) ? '0 : (period - 1'b1);
                        count_next = (period_m1 > {3'd0, ssr_pkg::COUNT_MAX})
                                   ? ssr_pkg::COUNT_MAX : period_m1[ssr_pkg::COUNT_W-1:0];
                        // ramp bookkeeping at the end of a full cycle
                        if (phase_next == ssr_pkg::PHASE_W'(ssr_pkg::PHASES - 1)
                            && ramp_active_next)
                        begin
                            cycles_in_stage_next = cycles_in_stage_next + 1'b1;
                            if (cycles_in_stage_next >= cycles_per_stage_reg)
                            begin
                                cycles_in_stage_next = 8'd0;
                                ramp_level_next      = ramp_level_next + 1'b1;
                                stages_left_next     = stages_left_next - 1'b1;
                                if (stages_left_next == 4'd0)
                                begin
                                    ramp_active_next = 1'b0;
                                end
                            end
                        end
                        phase_next = phase_next + 1'b1;
                    end
                end
            end
        end

        result = {rev, running_next && ramp_active_next, direction_next, running_next, coils};
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_level_reg      <= 4'd5;
            accel_level_reg      <= 4'd6;
            cycles_per_stage_reg <= 8'd30;
            base_ticks_reg       <= 16'd600;
            unit_ticks_reg       <= 16'd150;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssr_pkg::REG_SPEED_LEVEL:      speed_level_reg      <= cfg_data[3:0];
                ssr_pkg::REG_ACCEL_LEVEL:      accel_level_reg      <= cfg_data[3:0];
                ssr_pkg::REG_CYCLES_PER_STAGE: cycles_per_stage_reg <= cfg_data[7:0];
                ssr_pkg::REG_BASE_TICKS:       base_ticks_reg       <= cfg_data;
                ssr_pkg::REG_UNIT_TICKS:       unit_ticks_reg       <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // handshake valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beat payloads
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[3:0];
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    // motion state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg         <= 1'b0;
            direction_reg       <= 1'b0;
            phase_reg           <= '0;
            count_reg           <= '0;
            ramp_level_reg      <= 5'd0;
            stages_left_reg     <= 4'd0;
            cycles_in_stage_reg <= 8'd0;
            ramp_active_reg     <= 1'b0;
        end
        else if (fire)
        begin
            running_reg         <= running_next;
            direction_reg       <= direction_next;
            phase_reg           <= phase_next;
            count_reg           <= count_next;
            ramp_level_reg      <= ramp_level_next;
            stages_left_reg     <= stages_left_next;
            cycles_in_stage_reg <= cycles_in_stage_next;
            ramp_active_reg     <= ramp_active_next;
        end
    end

`ifndef SYNTHESIS
    // a reversal beat always has the coils off
    a_rev_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[7] |-> out_data_reg[3:0] == 4'd0)
        else $error("reversal beat with coils energised");

    // ramping is only reported while moving
    a_ramp_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg[6] |-> out_data_reg[4])
        else $error("ramping reported while stopped");

    // an idle shuttle has no ramp and sits at phase zero
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> !ramp_active_reg && phase_reg == '0)
        else $error("idle shuttle with ramp or phase left over");

    // an active ramp always has stages left
    a_ramp_stages: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_active_reg |-> stages_left_reg != 4'd0)
        else $error("ramp active with no stages left");
`endif

endmodule

### bench/tb.sv
// testbench for the stepper shuttle with ramp unit: directed and random ticks against a predictor
module tb;

    // result beat layout, lowest field in the lowest bits
    typedef struct packed {
        logic       reversed_now;
        logic       ramping;
        logic       heading_right;
        logic       moving;
        logic [3:0] coil_drive;
    } drive_t;

    // tick beat field positions
    localparam int START_BIT = 0;
    localparam int ABORT_BIT = 1;
    localparam int LEFT_BIT  = 2;
    localparam int RIGHT_BIT = 3;

    // tick commands used by the directed tests
    localparam logic [3:0] TICK_IDLE  = 4'b0000;
    localparam logic [3:0] TICK_START = 4'b0001;
    localparam logic [3:0] TICK_ABORT = 4'b0010;
    localparam logic [3:0] TICK_LEFT  = 4'b0100;
    localparam logic [3:0] TICK_RIGHT = 4'b1000;

    // forward (heading right) half-step sequence
    localparam logic [3:0] FWD_SEQ [0:7] = '{4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    wire                            s_axis_tready;
    logic [7:0]                     s_axis_tdata = 8'h00;   // start_cmd, abort_cmd, left_limit, right_limit, pad
    wire                            m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    wire  [7:0]                     m_axis_tdata;           // coil_drive[3:0], moving, heading_right, ramping, reversed_now
    logic                           cfg_valid = 1'b0;
    wire                            cfg_ready;
    logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // shadow registers
    logic [3:0]  speed_cfg = 4'd5;
    logic [3:0]  accel_cfg = 4'd6;
    logic [7:0]  stage_cycles_cfg = 8'd30;
    logic [15:0] base_cfg = 16'd600;
    logic [15:0] unit_cfg = 16'd150;

    // shuttle state mirror
    logic        run_on = 1'b0;
    logic        heading = 1'b0;
    logic [2:0]  phase = 3'd0;
    logic [16:0] countdown = '0;
    logic [4:0]  level = '0;
    logic [3:0]  stages = '0;
    logic [7:0]  cycles_done = '0;
    logic        ramp_on = 1'b0;

    drive_t pending_drive [$];
    int     fail_count = 0;
    int     stall_left = 0;
    bit     steady = 1'b0;

    stepper_shuttle_with_ramp_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // coil pattern for a phase in the current heading
    function automatic logic [3:0] coil_for(input logic [2:0] idx);
        return heading ? FWD_SEQ[idx] : FWD_SEQ[3'd7 - idx];
    endfunction

    // half-step length minus one, saturated to the counter
    function automatic logic [16:0] period_load();
        int unsigned     lvl;
        int unsigned     below;
        longint unsigned span;
        lvl = ramp_on ? 32'(level) : 32'(speed_cfg);
        below = (lvl >= 32'(ssr_pkg::LEVEL_TOP)) ? 0 : 32'(ssr_pkg::LEVEL_TOP) - lvl;
        span = longint'(base_cfg) + longint'(unit_cfg) * longint'(below);
        if (span == 0)
            span = 1;
        span = span - 1;
        return (span > 64'(ssr_pkg::COUNT_MAX)) ? ssr_pkg::COUNT_MAX : span[16:0];
    endfunction

    // start a fresh ramp from the current settings
    task automatic restart_ramp();
        int unsigned n;
        int unsigned s;
        n = (accel_cfg >= ssr_pkg::LEVEL_TOP) ? 0
          : 32'(ssr_pkg::LEVEL_TOP) - 32'(accel_cfg);
        s = 32'(speed_cfg);
        level = (s >= n) ? 5'(s - n) : 5'(n - s);
        stages = 4'(n);
        cycles_done = '0;
        ramp_on = (n > 0 && stage_cycles_cfg > 0);
    endtask

    // one timebase tick of the shuttle
    task automatic advance_shuttle(input logic [3:0] cmd, output drive_t res);
        logic hit;
        res = '0;
        if (cmd[ABORT_BIT])
        begin
            run_on = 1'b0;
            ramp_on = 1'b0;
            countdown = '0;
            phase = 3'd0;
        end
        else
        begin
            if (!run_on && cmd[START_BIT])
            begin
                run_on = 1'b1;
                heading = 1'b0;
                phase = 3'd0;
                countdown = '0;
                restart_ramp();
            end
            if (run_on)
            begin
                if (countdown > 0)
                begin
                    countdown = countdown - 17'd1;
                    res.coil_drive = coil_for(phase + 3'd7);
                end
                else
                begin
                    hit = heading ? cmd[RIGHT_BIT] : cmd[LEFT_BIT];
                    if (phase == 3'd0 && hit)
                    begin
                        heading = ~heading;
                        res.reversed_now = 1'b1;
                        restart_ramp();
                    end
                    else
                    begin
                        res.coil_drive = coil_for(phase);
                        countdown = period_load();
                        // cycle boundary bookkeeping for the ramp
                        if (phase == 3'd7 && ramp_on)
                        begin
                            cycles_done = cycles_done + 8'd1;
                            if (cycles_done >= stage_cycles_cfg)
                            begin
                                cycles_done = '0;
                                level = level + 5'd1;
                                stages = stages - 4'd1;
                                if (stages == 4'd0)
                                    ramp_on = 1'b0;
                            end
                        end
                        phase = phase + 3'd1;
                    end
                end
            end
        end
        res.moving = run_on;
        res.heading_right = heading;
        res.ramping = run_on && ramp_on;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // send one tick beat after a random gap, with no gap when steady
    task automatic send_tick(input logic [3:0] cmd);
        int     gap;
        drive_t res;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0000, cmd};
        do @(posedge clk); while (!s_axis_tready);
        advance_shuttle(cmd, res);
        pending_drive.push_back(res);
        @(negedge clk);
    endtask

    // hold the sender until every pending result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register write beat, valid left high for the caller
    task automatic write_reg(input logic [ssr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ssr_pkg::REG_SPEED_LEVEL:      speed_cfg = val[3:0];
            ssr_pkg::REG_ACCEL_LEVEL:      accel_cfg = val[3:0];
            ssr_pkg::REG_CYCLES_PER_STAGE: stage_cycles_cfg = val[7:0];
            ssr_pkg::REG_BASE_TICKS:       base_cfg = val;
            ssr_pkg::REG_UNIT_TICKS:       unit_cfg = val;
            default:                       ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] speed, input logic [15:0] accel,
                                  input logic [15:0] stage_cycles, input logic [15:0] base,
                                  input logic [15:0] unit);
        drain();
        write_reg(ssr_pkg::REG_SPEED_LEVEL, speed);
        write_reg(ssr_pkg::REG_ACCEL_LEVEL, accel);
        write_reg(ssr_pkg::REG_CYCLES_PER_STAGE, stage_cycles);
        write_reg(ssr_pkg::REG_BASE_TICKS, base);
        write_reg(ssr_pkg::REG_UNIT_TICKS, unit);
        cfg_valid <= 1'b0;
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = drive_t'(m_axis_tdata);
            if (pending_drive.size() == 0)
                report_mismatch("result beat with nothing pending", int'(m_axis_tdata), 0);
            else
            begin
                want = pending_drive.pop_front();
                if (got.coil_drive !== want.coil_drive)
                    report_mismatch("coil_drive", int'(got.coil_drive),
                                    int'(want.coil_drive));
                if (got.moving !== want.moving)
                    report_mismatch("moving", int'(got.moving), int'(want.moving));
                if (got.heading_right !== want.heading_right)
                    report_mismatch("heading_right", int'(got.heading_right),
                                    int'(want.heading_right));
                if (got.ramping !== want.ramping)
                    report_mismatch("ramping", int'(got.ramping), int'(want.ramping));
                if (got.reversed_now !== want.reversed_now)
                    report_mismatch("reversed_now", int'(got.reversed_now),
                                    int'(want.reversed_now));
            end
            stall_left = steady ? 0 : $urandom_range(0, 15);
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // reset defaults, start while running, abort over start
    task automatic test_defaults();
        send_tick(TICK_IDLE);
        send_tick(TICK_RIGHT);
        send_tick(TICK_LEFT | TICK_ABORT);
        send_tick(TICK_START);
        send_tick(TICK_IDLE);
        send_tick(TICK_IDLE);
        send_tick(TICK_START);
        send_tick(TICK_ABORT | TICK_START);
        send_tick(TICK_IDLE);
    endtask

    // register extremes, reversal on the start tick, off-heading switch, long period
    task automatic test_extremes();
        apply_settings(16'd15, 16'd0, 16'd255, 16'd0, 16'd0);
        send_tick(TICK_START | TICK_LEFT);
        send_tick(TICK_LEFT);
        send_tick(TICK_IDLE);
        send_tick(TICK_IDLE);
        send_tick(TICK_RIGHT);
        send_tick(TICK_ABORT);

        apply_settings(16'd0, 16'd15, 16'd0, 16'hFFFF, 16'hFFFF);
        send_tick(TICK_START);
        send_tick(TICK_IDLE);
        send_tick(TICK_RIGHT | TICK_LEFT);
        send_tick(TICK_ABORT);

        apply_settings(16'd10, 16'd10, 16'd1, 16'd1, 16'hFFFF);
        send_tick(TICK_START);
        send_tick(TICK_IDLE);
        send_tick(TICK_IDLE);
        send_tick(TICK_IDLE);
        send_tick(TICK_START | TICK_ABORT | TICK_LEFT | TICK_RIGHT);
    endtask

    // random settings and shuttle traffic, settings change while the shuttle moves
    task automatic test_random_motion(input int phases, input int per_phase);
        logic [15:0] speed;
        logic [15:0] accel;
        logic [15:0] stage_cycles;
        logic [15:0] base;
        logic [15:0] unit;
        logic [3:0]  cmd;
        int          limit_pct;
        int          abort_pct;
        for (int p = 0; p < phases; p++)
        begin
            speed = 16'($urandom_range(0, 15));
            accel = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                                : 16'($urandom_range(5, 9));
            case ($urandom_range(0, 7))
                0:       stage_cycles = 16'd0;
                1:       stage_cycles = 16'd255;
                default: stage_cycles = 16'($urandom_range(1, 3));
            endcase
            base = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 40))
                                               : 16'($urandom_range(0, 3));
            unit = 16'($urandom_range(0, 2));
            // junk in the unused upper bits now and then
            if ($urandom_range(0, 3) == 0)
            begin
                speed[15:4] = 12'($urandom);
                accel[15:4] = 12'($urandom);
                stage_cycles[15:8] = 8'($urandom);
            end
            apply_settings(speed, accel, stage_cycles, base, unit);
            limit_pct = $urandom_range(0, 1) ? 3 : 25;
            abort_pct = ($urandom_range(0, 5) == 0) ? 30 : 1;
            for (int k = 0; k < per_phase; k++)
            begin
                if ($urandom_range(0, 63) == 0)
                    steady = ~steady;
                if (k == per_phase / 2 && p % 3 == 0)
                    drain();
                cmd[START_BIT] = ($urandom_range(0, 5) == 0);
                cmd[ABORT_BIT] = ($urandom_range(0, 99) < abort_pct);
                cmd[LEFT_BIT] = ($urandom_range(0, 99) < limit_pct);
                cmd[RIGHT_BIT] = ($urandom_range(0, 99) < limit_pct);
                send_tick(cmd);
            end
        end
    endtask

    // run limit
    initial
    begin
        #4000000;
        $display("[stepper_shuttle_with_ramp_unit] ERROR");
        $finish;
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_defaults();
        test_extremes();
        test_random_motion(8, 235);
        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[stepper_shuttle_with_ramp_unit] OK");
        else
            $display("[stepper_shuttle_with_ramp_unit] ERROR");
        $finish;
    end

endmodule
